// ----- src/itf_pkg.sv -----
package itf_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int TAP_W         = 18;
  localparam int PHASE_W       = 24;
  localparam int TAP_IDX_W     = 5;
  localparam int DEF_TAP_COUNT = 32;

  localparam int PROD_W  = SAMPLE_W + TAP_W;
  localparam int DIFF_W  = TAP_W + 1;
  localparam int FPROD_W = DIFF_W + PHASE_W + 1;

  typedef enum logic {
    ACT_LOAD_TAP = 1'b0,
    ACT_SAMPLE   = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic issue;
    logic first;
    logic last;
  } mac_ctrl_t;

endpackage

// ----- src/itf_if.sv -----
interface itf_in_if import itf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [TAP_IDX_W-1:0]       tap_index;
  logic signed [TAP_W-1:0]    tap_value;

  modport source (output valid, action, sample_in, tap_index, tap_value, input ready);
  modport sink   (input valid, action, sample_in, tap_index, tap_value, output ready);
endinterface

interface itf_out_if import itf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

// ----- src/itf_ring.sv -----
module itf_ring import itf_pkg::*; #(
  parameter int TAP_COUNT = DEF_TAP_COUNT,
  localparam int AW = $clog2(TAP_COUNT)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [TAP_COUNT];
  logic [TAP_COUNT-1:0]       vld;
  logic signed [SAMPLE_W-1:0] rd_q;
  logic                       rd_vld;

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q   <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ----- src/itf_taps.sv -----
module itf_taps import itf_pkg::*; #(
  parameter int TAP_COUNT = DEF_TAP_COUNT,
  localparam int AW = $clog2(TAP_COUNT)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [TAP_W-1:0] wr_data,
  input  logic [AW-1:0]           rd_addr_a,
  input  logic [AW-1:0]           rd_addr_b,
  output logic signed [TAP_W-1:0] rd_a,
  output logic signed [TAP_W-1:0] rd_b
);

  logic signed [TAP_W-1:0] mem [TAP_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_addr_a];
    rd_b <= mem[rd_addr_b];
  end

endmodule

// ----- src/itf_mac.sv -----
module itf_mac import itf_pkg::*; #(
  parameter int TAP_COUNT = DEF_TAP_COUNT,
  localparam int ACC_W = PROD_W + $clog2(TAP_COUNT),
  localparam int YW = ACC_W - 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  mac_ctrl_t                  ctrl,
  input  logic [PHASE_W-1:0]         frac,
  input  logic signed [TAP_W-1:0]    tap_a,
  input  logic signed [TAP_W-1:0]    tap_b,
  input  logic signed [SAMPLE_W-1:0] smp,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam logic signed [YW-1:0] Y_MAX = YW'(2**(SAMPLE_W-1) - 1);
  localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;

  mac_ctrl_t tag1, tag2, tag3, tag4;
  logic      last5;

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PHASE_W:0]    frac_s;
  logic signed [FPROD_W-1:0]  p1;
  logic signed [FPROD_W-1:0]  p1_rnd;
  logic signed [TAP_W-1:0]    a2;
  logic signed [SAMPLE_W-1:0] s2, s3;
  logic signed [TAP_W-1:0]    tap3;
  logic signed [PROD_W-1:0]   p2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_rnd;
  logic signed [YW-1:0]       y;

  assign diff   = DIFF_W'(tap_b) - DIFF_W'(tap_a);
  assign frac_s = $signed({1'b0, frac});
  assign p1_rnd = p1 + FPROD_W'(2**(PHASE_W-1));
  assign acc_rnd = acc + ACC_W'(2**15);
  assign y = $signed(acc_rnd[ACC_W-1:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1  <= '0;
      tag2  <= '0;
      tag3  <= '0;
      tag4  <= '0;
      last5 <= 1'b0;
      done  <= 1'b0;
    end else begin
      tag1  <= ctrl;
      tag2  <= tag1;
      tag3  <= tag2;
      tag4  <= tag3;
      last5 <= tag4.issue & tag4.last;
      done  <= last5;
    end
  end

  // interp tap = a + round((b - a) * f / 2^24); last tap as stored
  always_ff @(posedge clk) begin
    p1   <= diff * frac_s;
    a2   <= tap_a;
    s2   <= smp;
    tap3 <= tag2.last ? a2 : a2 + p1_rnd[PHASE_W +: TAP_W];
    s3   <= s2;
    p2   <= s3 * tap3;
    if (tag4.issue) begin
      acc <= tag4.first ? ACC_W'(p2) : acc + ACC_W'(p2);
    end
    if (last5) begin
      if (y > Y_MAX) begin
        result <= Y_MAX[SAMPLE_W-1:0];
      end else if (y < Y_MIN) begin
        result <= Y_MIN[SAMPLE_W-1:0];
      end else begin
        result <= y[SAMPLE_W-1:0];
      end
    end
  end

endmodule

// ----- src/interpolated_tap_fir_filter.sv -----
// channel   | dir | fields                                   | notes
// in_ch     | in  | action, sample_in, tap_index, tap_value  | valid/ready transfer
// out_ch    | out | sample_out                               | valid/ready transfer
// cfg       | in  | cfg_wdata (phase_step)                   | cfg_we, no read-back
//
// Tap load: written directly; in_ch stays ready for the next transfer.
// Sample: one tap per cycle through the shared interpolate/multiply-accumulate
// pipeline, six stages deep.
// rst is synchronous and clears control state; the sample ring reads zero.
// A result waiting on out_ch does not block the next transfer on in_ch; the
// following result is held until out_ch drains.
module interpolated_tap_fir_filter import itf_pkg::*; #(
  parameter int TAP_COUNT = DEF_TAP_COUNT
) (
  input  logic               clk,
  input  logic               rst,
  itf_in_if.sink             in_ch,
  itf_out_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [PHASE_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TAP_COUNT);
  localparam int IW = ((AW > TAP_IDX_W) ? AW : TAP_IDX_W) + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(TAP_COUNT - 1);

  state_t state, state_next;

  logic [PHASE_W-1:0]         phase_step;
  logic [PHASE_W-1:0]         phase_acc;
  logic [PHASE_W-1:0]         frac;
  logic [AW-1:0]              wp, rp, cnt;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_data;

  logic          in_xfer, is_sample, start, out_load, tap_we;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] tap_addr_b;
  mac_ctrl_t     ctrl;

  logic signed [TAP_W-1:0]    tap_a, tap_b;
  logic signed [SAMPLE_W-1:0] smp;
  logic                       mac_done;
  logic signed [SAMPLE_W-1:0] mac_result;

  assign in_xfer   = in_ch.valid & in_ch.ready;
  assign is_sample = (in_ch.action == ACT_SAMPLE);
  assign start     = in_xfer & is_sample;
  assign idx_ext   = IW'(in_ch.tap_index);
  assign tap_we    = in_xfer & ~is_sample & (idx_ext < IW'(TAP_COUNT));

  assign ctrl.issue = (state == ST_RUN);
  assign ctrl.first = (cnt == '0);
  assign ctrl.last  = (cnt == LAST_IDX);
  assign tap_addr_b = ctrl.last ? cnt : cnt + 1'b1;

  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && is_sample) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ctrl.last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
      phase_acc  <= '0;
      wp         <= '0;
      rp         <= '0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        phase_step <= cfg_wdata;
      end
      if (start) begin
        phase_acc <= phase_acc + phase_step;
        wp        <= (wp == LAST_IDX) ? '0 : wp + 1'b1;
        rp        <= wp;
        cnt       <= '0;
      end else if (ctrl.issue) begin
        rp  <= (rp == '0) ? LAST_IDX : rp - 1'b1;
        cnt <= cnt + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      frac <= phase_acc;
    end
    if (out_load) begin
      out_data <= mac_result;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_data;

  itf_ring #(.TAP_COUNT(TAP_COUNT)) u_ring (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (start),
    .wr_addr (wp),
    .wr_data (in_ch.sample_in),
    .rd_addr (rp),
    .rd_data (smp)
  );

  itf_taps #(.TAP_COUNT(TAP_COUNT)) u_taps (
    .clk       (clk),
    .wr_en     (tap_we),
    .wr_addr   (idx_ext[AW-1:0]),
    .wr_data   (in_ch.tap_value),
    .rd_addr_a (cnt),
    .rd_addr_b (tap_addr_b),
    .rd_a      (tap_a),
    .rd_b      (tap_b)
  );

  itf_mac #(.TAP_COUNT(TAP_COUNT)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .frac   (frac),
    .tap_a  (tap_a),
    .tap_b  (tap_b),
    .smp    (smp),
    .done   (mac_done),
    .result (mac_result)
  );

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> state == ST_WAIT)
    else $error("accumulator finished outside wait state");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ch.ready))
    else $error("pending result overwritten");

  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    start |=> phase_acc == PHASE_W'($past(phase_acc) + $past(phase_step)))
    else $error("phase did not advance by step");

endmodule
